FILE: rtl/core/ubhp_pkg.sv
// Shared types and constants for the UART bootloader host protocol block.
package ubhp_pkg;

	localparam int MAX_CHUNK = 256;
	localparam int QDEPTH    = 4;

	typedef enum logic [3:0] {
		PH_IDLE, PH_SYNC_ACK, PH_CMD_ACK, PH_RX_COUNT, PH_RX_LIST, PH_ADDR_ACK,
		PH_LEN_ACK, PH_RX_DATA, PH_PAYLOAD, PH_FINAL_ACK, PH_ERASE_ACK
	} phase_t;

	typedef enum logic [2:0] {
		OP_NONE, OP_GET, OP_GETID, OP_READ, OP_WRITE, OP_EXT_ERASE, OP_STD_ERASE, OP_GO
	} oper_t;

	localparam logic [3:0] EV_SYNC = 4'd0;
	localparam logic [3:0] EV_GET = 4'd1;
	localparam logic [3:0] EV_GETID = 4'd2;
	localparam logic [3:0] EV_READ = 4'd3;
	localparam logic [3:0] EV_WRITE = 4'd4;
	localparam logic [3:0] EV_ERASE = 4'd5;
	localparam logic [3:0] EV_GO = 4'd6;
	localparam logic [3:0] EV_PAYLOAD = 4'd7;
	localparam logic [3:0] EV_RX = 4'd8;
	localparam logic [3:0] EV_TICK = 4'd9;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_TIMEOUT = 3'd1;
	localparam logic [2:0] ST_NACK = 3'd2;
	localparam logic [2:0] ST_PROTOCOL = 3'd3;
	localparam logic [2:0] ST_UNSUPPORTED = 3'd4;
	localparam logic [2:0] ST_NOSYNC = 3'd5;
	localparam logic [2:0] ST_BADARG = 3'd6;

	localparam logic [1:0] K_TX = 2'd0;
	localparam logic [1:0] K_VER = 2'd1;
	localparam logic [1:0] K_DATA = 2'd2;
	localparam logic [1:0] K_DONE = 2'd3;

	localparam logic [7:0] B_SYNC = 8'h7F;
	localparam logic [7:0] B_ACK = 8'h79;
	localparam logic [7:0] B_NACK = 8'h1F;
	localparam logic [7:0] C_GET = 8'h00;
	localparam logic [7:0] C_GETID = 8'h02;
	localparam logic [7:0] C_READ = 8'h11;
	localparam logic [7:0] C_GO = 8'h21;
	localparam logic [7:0] C_WRITE = 8'h31;
	localparam logic [7:0] C_ERASE = 8'h43;
	localparam logic [7:0] C_EXT_ERASE = 8'h44;
	localparam logic [7:0] B_FF = 8'hFF;

	localparam logic [0:0] ADDR_CMD_TO = 1'b0;
	localparam logic [0:0] ADDR_ERASE_TO = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  byte_out;
		logic [2:0]  status;
		logic [15:0] chip_id;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [31:0] address;
		logic [8:0]  length;
		logic [7:0]  byte_value;
	} event_t;

endpackage

FILE: rtl/core/ubhp_front.sv
// Input skid queue: accepts events and drops undefined opcodes.
module ubhp_front #(
	parameter int QDEPTH = ubhp_pkg::QDEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ubhp_pkg::event_t  in_ev,
	output logic              ev_valid,
	input  logic              ev_take,
	output ubhp_pkg::event_t  ev
);
	localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	ubhp_pkg::event_t mem_q [QDEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          push, pop;

	assign in_ready = (cnt_q != (AW+1)'(QDEPTH));
	assign push = in_valid && in_ready && (in_ev.opcode <= ubhp_pkg::EV_TICK);
	assign ev_valid = (cnt_q != '0);
	assign pop = ev_valid && ev_take;
	assign ev = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(QDEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(QDEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

FILE: rtl/core/ubhp_back.sv
// Protocol engine: executes one event, then drains its results one per cycle while res_ready is high.
module ubhp_back #(
	parameter int MAX_CHUNK = ubhp_pkg::MAX_CHUNK
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ev_valid,
	output logic               ev_take,
	input  ubhp_pkg::event_t   ev,
	input  logic [31:0]        cmd_to,
	input  logic [31:0]        erase_to,
	output logic               res_valid,
	input  logic               res_ready,
	output ubhp_pkg::result_t  res
);
	ubhp_pkg::phase_t phase_q, ph_d;
	ubhp_pkg::oper_t  op_q, op_d;
	logic synced_q, caps_q, rd_q, er_q, ext_q, fb_q, pend_r_q, pend_e_q, pend_x_q;
	logic synced_d, caps_d, rd_d, er_d, ext_d, fb_d, pend_r_d, pend_e_d, pend_x_d;
	logic [31:0] timer_q, timer_d, addr_q, addr_d;
	logic [8:0]  len_q, len_d, cnt_q, cnt_d;
	logic [7:0]  csum_q, csum_d;
	logic [15:0] id_q, id_d;

	ubhp_pkg::result_t buf_q [5];
	ubhp_pkg::result_t nb [5];
	logic [2:0] n_q, idx_q, n;

	logic busy, take;
	assign busy = (n_q != '0);
	assign ev_take = !busy || (res_ready && (idx_q == n_q - 3'd1));
	assign take = ev_valid && ev_take;
	assign res_valid = busy;
	always_comb begin
		res = buf_q[idx_q];
		res.last = (idx_q == n_q - 3'd1);
	end

	logic bad_len, is_req, timeout;
	logic [7:0] lm1, b3, b2, b1, b0, bv;
	logic [31:0] tnext, limit;

	always_comb begin
		ph_d = phase_q; op_d = op_q; synced_d = synced_q; caps_d = caps_q;
		rd_d = rd_q; er_d = er_q; ext_d = ext_q; fb_d = fb_q;
		pend_r_d = pend_r_q; pend_e_d = pend_e_q; pend_x_d = pend_x_q;
		timer_d = timer_q; addr_d = addr_q; len_d = len_q; cnt_d = cnt_q;
		csum_d = csum_q; id_d = id_q;
		n = '0;
		for (int i = 0; i < 5; i++) begin
			nb[i] = '0;
		end
		bv = ev.byte_value;
		bad_len = (ev.length == 9'd0) || (32'(ev.length) > 32'(MAX_CHUNK));
		lm1 = 8'(len_q - 9'd1);
		b3 = addr_q[31:24]; b2 = addr_q[23:16]; b1 = addr_q[15:8]; b0 = addr_q[7:0];
		is_req = (ev.opcode <= ubhp_pkg::EV_GO);
		limit = (phase_q == ubhp_pkg::PH_ERASE_ACK) ? erase_to : cmd_to;
		tnext = (timer_q != 32'hFFFF_FFFF) ? timer_q + 32'd1 : timer_q;
		timeout = 1'b0;

		if (take) begin
			if (is_req) begin
				if (phase_q == ubhp_pkg::PH_IDLE) begin
					addr_d = ev.address;
					len_d = ev.length;
					fb_d = 1'b0;
					unique case (ev.opcode)
						ubhp_pkg::EV_SYNC: op_d = ubhp_pkg::OP_NONE;
						ubhp_pkg::EV_GET: op_d = ubhp_pkg::OP_GET;
						ubhp_pkg::EV_GETID: op_d = ubhp_pkg::OP_GETID;
						ubhp_pkg::EV_READ: op_d = ubhp_pkg::OP_READ;
						ubhp_pkg::EV_WRITE: op_d = ubhp_pkg::OP_WRITE;
						ubhp_pkg::EV_ERASE: begin
							if (!caps_q) begin
								op_d = ubhp_pkg::OP_EXT_ERASE;
								fb_d = 1'b1;
							end else if (ext_q) op_d = ubhp_pkg::OP_EXT_ERASE;
							else op_d = ubhp_pkg::OP_STD_ERASE;
						end
						default: op_d = ubhp_pkg::OP_GO;
					endcase
					n = 3'd1;
					if (ev.opcode == ubhp_pkg::EV_SYNC) begin
						synced_d = 1'b0;
						nb[0].byte_out = ubhp_pkg::B_SYNC;
						ph_d = ubhp_pkg::PH_SYNC_ACK;
						timer_d = '0;
					end else if ((ev.opcode == ubhp_pkg::EV_READ
							|| ev.opcode == ubhp_pkg::EV_WRITE) && bad_len) begin
						nb[0].kind = ubhp_pkg::K_DONE;
						nb[0].status = ubhp_pkg::ST_BADARG;
						op_d = ubhp_pkg::OP_NONE;
					end else if ((ev.opcode == ubhp_pkg::EV_READ && caps_q && !rd_q)
							|| (ev.opcode == ubhp_pkg::EV_ERASE && caps_q && !ext_q && !er_q)) begin
						nb[0].kind = ubhp_pkg::K_DONE;
						nb[0].status = ubhp_pkg::ST_UNSUPPORTED;
						op_d = ubhp_pkg::OP_NONE;
					end else if (!synced_q) begin
						nb[0].kind = ubhp_pkg::K_DONE;
						nb[0].status = ubhp_pkg::ST_NOSYNC;
						op_d = ubhp_pkg::OP_NONE;
					end else begin
						n = 3'd2;
						unique case (op_d)
							ubhp_pkg::OP_GET: nb[0].byte_out = ubhp_pkg::C_GET;
							ubhp_pkg::OP_GETID: nb[0].byte_out = ubhp_pkg::C_GETID;
							ubhp_pkg::OP_READ: nb[0].byte_out = ubhp_pkg::C_READ;
							ubhp_pkg::OP_WRITE: nb[0].byte_out = ubhp_pkg::C_WRITE;
							ubhp_pkg::OP_EXT_ERASE: nb[0].byte_out = ubhp_pkg::C_EXT_ERASE;
							ubhp_pkg::OP_STD_ERASE: nb[0].byte_out = ubhp_pkg::C_ERASE;
							default: nb[0].byte_out = ubhp_pkg::C_GO;
						endcase
						nb[1].byte_out = ~nb[0].byte_out;
						ph_d = ubhp_pkg::PH_CMD_ACK;
						timer_d = '0;
					end
				end
			end else if (ev.opcode == ubhp_pkg::EV_PAYLOAD) begin
				if (phase_q == ubhp_pkg::PH_PAYLOAD) begin
					n = 3'd1;
					nb[0].byte_out = bv;
					csum_d = csum_q ^ bv;
					cnt_d = cnt_q + 9'd1;
					if (cnt_d >= len_q) begin
						n = 3'd2;
						nb[1].byte_out = csum_d;
						ph_d = ubhp_pkg::PH_FINAL_ACK;
						timer_d = '0;
					end
				end
			end else if (ev.opcode == ubhp_pkg::EV_TICK) begin
				if (phase_q != ubhp_pkg::PH_IDLE && phase_q != ubhp_pkg::PH_PAYLOAD) begin
					timer_d = tnext;
					timeout = (tnext >= limit);
				end
			end else begin
				unique case (phase_q)
					ubhp_pkg::PH_SYNC_ACK, ubhp_pkg::PH_CMD_ACK, ubhp_pkg::PH_ADDR_ACK,
					ubhp_pkg::PH_LEN_ACK, ubhp_pkg::PH_FINAL_ACK,
					ubhp_pkg::PH_ERASE_ACK: begin
						if (bv == ubhp_pkg::B_ACK) begin
							timer_d = '0;
							unique case (phase_q)
								ubhp_pkg::PH_SYNC_ACK: begin
									synced_d = 1'b1;
									n = 3'd1;
									nb[0].kind = ubhp_pkg::K_DONE;
									ph_d = ubhp_pkg::PH_IDLE;
									op_d = ubhp_pkg::OP_NONE;
								end
								ubhp_pkg::PH_CMD_ACK: begin
									if (op_q == ubhp_pkg::OP_GET || op_q == ubhp_pkg::OP_GETID) begin
										ph_d = ubhp_pkg::PH_RX_COUNT;
									end else if (op_q == ubhp_pkg::OP_EXT_ERASE) begin
										n = 3'd3;
										nb[0].byte_out = ubhp_pkg::B_FF;
										nb[1].byte_out = ubhp_pkg::B_FF;
										ph_d = ubhp_pkg::PH_ERASE_ACK;
									end else if (op_q == ubhp_pkg::OP_STD_ERASE) begin
										n = 3'd2;
										nb[0].byte_out = ubhp_pkg::B_FF;
										ph_d = ubhp_pkg::PH_ERASE_ACK;
									end else begin
										n = 3'd5;
										nb[0].byte_out = b3;
										nb[1].byte_out = b2;
										nb[2].byte_out = b1;
										nb[3].byte_out = b0;
										nb[4].byte_out = b3 ^ b2 ^ b1 ^ b0;
										ph_d = ubhp_pkg::PH_ADDR_ACK;
									end
								end
								ubhp_pkg::PH_ADDR_ACK: begin
									if (op_q == ubhp_pkg::OP_READ) begin
										n = 3'd2;
										nb[0].byte_out = lm1;
										nb[1].byte_out = ~lm1;
										ph_d = ubhp_pkg::PH_LEN_ACK;
									end else if (op_q == ubhp_pkg::OP_WRITE) begin
										n = 3'd1;
										nb[0].byte_out = lm1;
										csum_d = lm1;
										cnt_d = '0;
										ph_d = ubhp_pkg::PH_PAYLOAD;
									end else begin
										n = 3'd1;
										nb[0].kind = ubhp_pkg::K_DONE;
										ph_d = ubhp_pkg::PH_IDLE;
										op_d = ubhp_pkg::OP_NONE;
									end
								end
								ubhp_pkg::PH_LEN_ACK: begin
									cnt_d = '0;
									ph_d = ubhp_pkg::PH_RX_DATA;
								end
								ubhp_pkg::PH_FINAL_ACK: begin
									n = 3'd1;
									nb[0].kind = ubhp_pkg::K_DONE;
									ph_d = ubhp_pkg::PH_IDLE;
									op_d = ubhp_pkg::OP_NONE;
									if (op_q == ubhp_pkg::OP_GET) begin
										caps_d = 1'b1;
										rd_d = pend_r_q;
										er_d = pend_e_q;
										ext_d = pend_x_q;
									end else if (op_q == ubhp_pkg::OP_GETID) begin
										if (len_q < 9'd2) nb[0].status = ubhp_pkg::ST_PROTOCOL;
										else nb[0].chip_id = id_q;
									end
								end
								default: begin
									n = 3'd1;
									nb[0].kind = ubhp_pkg::K_DONE;
									ph_d = ubhp_pkg::PH_IDLE;
									op_d = ubhp_pkg::OP_NONE;
								end
							endcase
						end else begin
							timeout = 1'b1;
						end
					end
					ubhp_pkg::PH_RX_COUNT: begin
						len_d = {1'b0, bv} + 9'd1;
						cnt_d = '0;
						id_d = '0;
						pend_r_d = 1'b0; pend_e_d = 1'b0; pend_x_d = 1'b0;
						ph_d = ubhp_pkg::PH_RX_LIST;
						timer_d = '0;
					end
					ubhp_pkg::PH_RX_LIST: begin
						if (op_q == ubhp_pkg::OP_GET) begin
							n = 3'd1;
							nb[0].byte_out = bv;
							if (cnt_q == '0) nb[0].kind = ubhp_pkg::K_VER;
							else begin
								nb[0].kind = ubhp_pkg::K_DATA;
								if (bv == ubhp_pkg::C_READ) pend_r_d = 1'b1;
								if (bv == ubhp_pkg::C_ERASE) pend_e_d = 1'b1;
								if (bv == ubhp_pkg::C_EXT_ERASE) pend_x_d = 1'b1;
							end
						end else begin
							id_d = {id_q[7:0], bv};
						end
						cnt_d = cnt_q + 9'd1;
						if (cnt_d >= len_q) begin
							ph_d = ubhp_pkg::PH_FINAL_ACK;
							timer_d = '0;
						end
					end
					ubhp_pkg::PH_RX_DATA: begin
						n = 3'd1;
						nb[0].kind = ubhp_pkg::K_DATA;
						nb[0].byte_out = bv;
						cnt_d = cnt_q + 9'd1;
						if (cnt_d >= len_q) begin
							n = 3'd2;
							nb[1].kind = ubhp_pkg::K_DONE;
							ph_d = ubhp_pkg::PH_IDLE;
							op_d = ubhp_pkg::OP_NONE;
						end
					end
					default: ;
				endcase
			end

			if (timeout) begin
				n = 3'd1;
				if (ev.opcode == ubhp_pkg::EV_TICK) nb[0].status = ubhp_pkg::ST_TIMEOUT;
				else if (bv == ubhp_pkg::B_NACK) nb[0].status = ubhp_pkg::ST_NACK;
				else nb[0].status = ubhp_pkg::ST_PROTOCOL;
				if (op_q == ubhp_pkg::OP_EXT_ERASE && fb_q
						&& nb[0].status == ubhp_pkg::ST_NACK) begin
					n = 3'd2;
					fb_d = 1'b0;
					op_d = ubhp_pkg::OP_STD_ERASE;
					nb[0].status = ubhp_pkg::ST_OK;
					nb[0].byte_out = ubhp_pkg::C_ERASE;
					nb[1].byte_out = ~ubhp_pkg::C_ERASE;
					ph_d = ubhp_pkg::PH_CMD_ACK;
					timer_d = '0;
				end else begin
					nb[0].kind = ubhp_pkg::K_DONE;
					ph_d = ubhp_pkg::PH_IDLE;
					op_d = ubhp_pkg::OP_NONE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < 5; i++) begin
				buf_q[i] <= nb[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ubhp_pkg::PH_IDLE;
			op_q <= ubhp_pkg::OP_NONE;
			{synced_q, caps_q, rd_q, er_q, ext_q, fb_q} <= '0;
			{pend_r_q, pend_e_q, pend_x_q} <= '0;
			timer_q <= '0; addr_q <= '0; len_q <= '0; cnt_q <= '0;
			csum_q <= '0; id_q <= '0;
			n_q <= '0; idx_q <= '0;
		end else begin
			phase_q <= ph_d; op_q <= op_d;
			synced_q <= synced_d; caps_q <= caps_d; rd_q <= rd_d; er_q <= er_d;
			ext_q <= ext_d; fb_q <= fb_d;
			pend_r_q <= pend_r_d; pend_e_q <= pend_e_d; pend_x_q <= pend_x_d;
			timer_q <= timer_d; addr_q <= addr_d; len_q <= len_d; cnt_q <= cnt_d;
			csum_q <= csum_d; id_q <= id_d;
			if (take) begin
				n_q <= n;
				idx_q <= '0;
			end else if (busy && res_ready) begin
				if (idx_q == n_q - 3'd1) begin
					n_q <= '0;
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end
endmodule

FILE: rtl/core/uart_bootloader_host_protocol.sv
// Top level of the UART bootloader host protocol engine.
// Events (requests, payload bytes, received bytes, ms ticks) enter a 4-deep queue; the
// engine takes an event when its result buffer is empty or its last result leaves in that
// cycle, and presents that event's 0..5 results one per cycle while m_axis_tready is high
// on the output stream, the last marked by tlast. The event opcode travels in s_axis_tuser,
// the result kind in m_axis_tuser. Timeout registers: 0x0 command timeout, 0x4 erase
// timeout; writing zero is ignored.
module uart_bootloader_host_protocol #(
	parameter int MAX_CHUNK = ubhp_pkg::MAX_CHUNK,
	parameter int QDEPTH    = ubhp_pkg::QDEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata, // address, length, byte_value, zero fill
	input  logic [3:0]  s_axis_tuser, // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata, // byte_out, status, chip_id, zero fill
	output logic [1:0]  m_axis_tuser, // kind
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [31:0] cmd_to_q, erase_to_q;
	logic wr;
	logic ev_valid, ev_take;
	ubhp_pkg::event_t in_ev, ev;
	ubhp_pkg::result_t res;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && (pwdata != '0);
	assign prdata = (paddr[2] == ubhp_pkg::ADDR_ERASE_TO) ? erase_to_q : cmd_to_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_to_q <= 32'd1000;
			erase_to_q <= 32'd30000;
		end else if (wr && paddr[1:0] == 2'b00) begin
			if (paddr[2] == ubhp_pkg::ADDR_CMD_TO) cmd_to_q <= pwdata;
			else erase_to_q <= pwdata;
		end
	end

	assign in_ev.opcode = s_axis_tuser;
	assign in_ev.address = s_axis_tdata[31:0];
	assign in_ev.length = s_axis_tdata[40:32];
	assign in_ev.byte_value = s_axis_tdata[48:41];

	ubhp_front #(.QDEPTH(QDEPTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_ev(in_ev),
		.ev_valid(ev_valid), .ev_take(ev_take), .ev(ev)
	);

	ubhp_back #(.MAX_CHUNK(MAX_CHUNK)) u_back (
		.clk(clk), .arst_n(arst_n),
		.ev_valid(ev_valid), .ev_take(ev_take), .ev(ev),
		.cmd_to(cmd_to_q), .erase_to(erase_to_q),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {5'b00000, res.chip_id, res.status, res.byte_out};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;
endmodule
